>>> src/cosu_pkg.sv
// Shared widths, types and codes of the cosine similarity unit.
package cosu_pkg;

    localparam int ELEMENT_BITS = 16;
    localparam int FRAC_BITS    = ELEMENT_BITS - 1;
    localparam int PROD_W       = 2 * ELEMENT_BITS;
    localparam int ACC_W        = 48;
    localparam int HALF_W       = ACC_W / 2;
    localparam int FULL_W       = 2 * ACC_W;
    localparam int WIDE_W       = FULL_W + 2 * FRAC_BITS + 2;
    localparam int Q_W          = ELEMENT_BITS;
    localparam int CNT_W        = $clog2(ELEMENT_BITS);
    localparam int STEP_W       = 3;

    localparam logic [STEP_W-1:0] MUL_STEP_LAST = '1;

    typedef logic signed [ELEMENT_BITS-1:0] elem_t;

    typedef enum logic [8:0] {
        S_ACCUM = 9'b000000001,
        S_DRAIN = 9'b000000010,
        S_SETUP = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_MWAIT = 9'b000010000,
        S_INIT  = 9'b000100000,
        S_TERM  = 9'b001000000,
        S_TEST  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic              take;
        logic              setup;
        logic              mul_en;
        logic [STEP_W-1:0] mul_step;
        logic              wide_init;
        logic              term;
        logic              test;
        logic [CNT_W-1:0]  bit_idx;
        logic              load_out;
    } cmd_t;

    typedef struct packed {
        logic zero_norm;
        logic out_free;
    } sts_t;

endpackage

>>> src/cosu_if.sv
// Valid/ready channels for element pairs and similarity results.
interface cosu_in_if import cosu_pkg::*; ();
    logic  valid;
    logic  ready;
    elem_t elem_a;
    elem_t elem_b;
    logic  last_element;

    modport source (output valid, output elem_a, output elem_b, output last_element,
                    input ready);
    modport sink   (input valid, input elem_a, input elem_b, input last_element,
                    output ready);
endinterface

interface cosu_out_if import cosu_pkg::*; ();
    logic  valid;
    logic  ready;
    elem_t similarity;
    logic  zero_norm;

    modport source (output valid, output similarity, output zero_norm, input ready);
    modport sink   (input valid, input similarity, input zero_norm, output ready);
endinterface

>>> src/cosu_ctrl.sv
// Controller state machine that sequences accumulate, multiply, root-divide and output.
module cosu_ctrl import cosu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic last_element,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACCUM;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.bit_idx  = cnt_reg;
        cmd.mul_step = cnt_reg[STEP_W-1:0];
        unique case (state_reg)
            S_ACCUM:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid && last_element)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.setup = 1'b1;
                cnt_next  = '0;
                if (sts.zero_norm)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg[STEP_W-1:0] == MUL_STEP_LAST)
                begin
                    state_next = S_MWAIT;
                end
            end
            S_MWAIT:
            begin
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.wide_init = 1'b1;
                cnt_next      = CNT_W'(FRAC_BITS);
                state_next    = S_TERM;
            end
            S_TERM:
            begin
                cmd.term   = 1'b1;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                cmd.test = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_TERM;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_ACCUM;
                end
            end
            default:
            begin
                state_next = S_ACCUM;
            end
        endcase
    end

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && last_element) |=> (state_reg == S_DRAIN))
        else $error("last word did not start the drain");

    a_root_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST && cnt_reg == '0) |=> (state_reg == S_DONE))
        else $error("root search did not end after the lowest bit");

endmodule

>>> src/cosu_dp.sv
// Datapath: multiply-accumulate, shared partial-product multiplier, bit-serial root-divide.
module cosu_dp import cosu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    output sts_t  sts,
    input  elem_t elem_a,
    input  elem_t elem_b,
    input  logic  out_ready,
    output logic  out_valid,
    output elem_t similarity,
    output logic  zero_norm
);

    // product stage
    logic signed [PROD_W-1:0] prod_d, prod_a, prod_b;
    logic signed [PROD_W-1:0] pd_reg;
    logic        [PROD_W-1:0] pa_reg, pb_reg;
    logic                     pv_reg;

    assign prod_d = elem_a * elem_b;
    assign prod_a = elem_a * elem_a;
    assign prod_b = elem_b * elem_b;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pd_reg <= prod_d;
            pa_reg <= unsigned'(prod_a);
            pb_reg <= unsigned'(prod_b);
        end
    end

    // accumulators
    logic signed [ACC_W-1:0] dot_reg;
    logic        [ACC_W-1:0] na_reg, nb_reg;
    logic signed [ACC_W:0]   dot_sum;
    logic        [ACC_W:0]   na_sum, nb_sum;
    logic signed [ACC_W-1:0] dot_sat;
    logic        [ACC_W-1:0] na_sat, nb_sat;

    assign dot_sum = {dot_reg[ACC_W-1], dot_reg} + (ACC_W+1)'(pd_reg);
    assign na_sum  = {1'b0, na_reg} + (ACC_W+1)'(pa_reg);
    assign nb_sum  = {1'b0, nb_reg} + (ACC_W+1)'(pb_reg);

    always_comb
    begin
        if (dot_sum[ACC_W] != dot_sum[ACC_W-1])
        begin
            dot_sat = dot_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            dot_sat = dot_sum[ACC_W-1:0];
        end
        na_sat = na_sum[ACC_W] ? '1 : na_sum[ACC_W-1:0];
        nb_sat = nb_sum[ACC_W] ? '1 : nb_sum[ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg  <= 1'b0;
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
        end
        else
        begin
            pv_reg <= cmd.take;
            if (cmd.setup)
            begin
                dot_reg <= '0;
                na_reg  <= '0;
                nb_reg  <= '0;
            end
            else if (pv_reg)
            begin
                dot_reg <= dot_sat;
                na_reg  <= na_sat;
                nb_reg  <= nb_sat;
            end
        end
    end

    assign sts.zero_norm = (na_reg == '0) || (nb_reg == '0);

    // latched operands of the final computation
    logic [ACC_W-1:0] mag_reg, na_l_reg, nb_l_reg;
    logic             neg_reg, zero_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            mag_reg  <= dot_reg[ACC_W-1] ? unsigned'(-dot_reg) : unsigned'(dot_reg);
            neg_reg  <= dot_reg[ACC_W-1];
            zero_reg <= sts.zero_norm;
            na_l_reg <= na_reg;
            nb_l_reg <= nb_reg;
        end
    end

    // shared multiplier: norm product, then squared dot magnitude
    logic [ACC_W-1:0]  mx, my;
    logic [HALF_W-1:0] mxs, mys;
    logic [ACC_W-1:0]  mp_reg;
    logic [1:0]        msh_reg;
    logic              mdst_reg, mv_reg;
    logic [FULL_W-1:0] mp_shifted;
    logic [FULL_W-1:0] p_reg, d_reg;

    assign mx  = cmd.mul_step[2] ? mag_reg : na_l_reg;
    assign my  = cmd.mul_step[2] ? mag_reg : nb_l_reg;
    assign mxs = cmd.mul_step[1] ? mx[ACC_W-1:HALF_W] : mx[HALF_W-1:0];
    assign mys = cmd.mul_step[0] ? my[ACC_W-1:HALF_W] : my[HALF_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            mp_reg   <= mxs * mys;
            msh_reg  <= 2'(cmd.mul_step[1]) + 2'(cmd.mul_step[0]);
            mdst_reg <= cmd.mul_step[2];
        end
    end

    always_comb
    begin
        case (msh_reg)
            2'd1:    mp_shifted = {{HALF_W{1'b0}}, mp_reg, {HALF_W{1'b0}}};
            2'd2:    mp_shifted = {mp_reg, {ACC_W{1'b0}}};
            default: mp_shifted = {{ACC_W{1'b0}}, mp_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
        end
        else
        begin
            mv_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            p_reg <= '0;
            d_reg <= '0;
        end
        else if (mv_reg)
        begin
            if (mdst_reg)
            begin
                d_reg <= d_reg + mp_shifted;
            end
            else
            begin
                p_reg <= p_reg + mp_shifted;
            end
        end
    end

    // restoring root-divide, one quotient bit per term and test step pair
    logic [WIDE_W-1:0] e_reg, u_reg, ps_reg, term_reg;
    logic [WIDE_W:0]   diff;
    logic [Q_W-1:0]    q_reg;
    logic              take_bit;

    assign diff     = {1'b0, e_reg} - {1'b0, term_reg};
    assign take_bit = !diff[WIDE_W] && !q_reg[Q_W-1];

    always_ff @(posedge clk)
    begin
        if (cmd.wide_init)
        begin
            e_reg  <= WIDE_W'({d_reg, {(2*FRAC_BITS){1'b0}}});
            ps_reg <= WIDE_W'({p_reg, {(2*FRAC_BITS){1'b0}}});
            u_reg  <= '0;
            q_reg  <= '0;
        end
        else if (cmd.term)
        begin
            term_reg <= u_reg + ps_reg;
        end
        else if (cmd.test)
        begin
            ps_reg <= ps_reg >> 2;
            if (take_bit)
            begin
                e_reg <= diff[WIDE_W-1:0];
                q_reg <= q_reg | (Q_W'(1) << cmd.bit_idx);
                u_reg <= (term_reg + ps_reg) >> 1;
            end
            else
            begin
                u_reg <= u_reg >> 1;
            end
        end
    end

    // output register
    elem_t sim_c;
    elem_t sim_reg;
    logic  zn_reg, out_vld_reg;

    always_comb
    begin
        if (zero_reg)
        begin
            sim_c = '0;
        end
        else if (neg_reg)
        begin
            sim_c = elem_t'(~q_reg + Q_W'(1));
        end
        else if (q_reg[Q_W-1])
        begin
            sim_c = {1'b0, {(Q_W-1){1'b1}}};
        end
        else
        begin
            sim_c = elem_t'(q_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            sim_reg <= sim_c;
            zn_reg  <= zero_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    assign sts.out_free = !out_vld_reg || out_ready;
    assign out_valid    = out_vld_reg;
    assign similarity   = sim_reg;
    assign zero_norm    = zn_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_vld_reg || out_ready))
        else $error("result word overwritten before it was taken");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && zn_reg) |-> (sim_reg == '0))
        else $error("zero-norm word carries a nonzero similarity");

    a_setup_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.setup |=> (dot_reg == '0 && na_reg == '0 && nb_reg == '0))
        else $error("accumulators not cleared after a vector");

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.test |=> (q_reg <= (Q_W'(1) << FRAC_BITS)))
        else $error("quotient above one");

endmodule

>>> src/cosine_similarity_unit.sv
// Top level of the streaming cosine similarity unit.
//
// Usage: element pairs (elem_a, elem_b, signed Q1.15) arrive as words on the
// samples channel, one word per cycle while samples.ready is high. The word
// with last_element set closes the vector. One result word (similarity in
// signed Q1.15, saturated at 32767 for plus one, and zero_norm) then leaves
// on the result channel.
// Throughput: words of a vector are taken back to back, one per cycle,
// through the three 16x16 multipliers and the saturating accumulators.
// After the last word, samples.ready stays low for the finishing work:
// drain, setup, 8 steps of the shared 24x24 multiplier, one add, one
// operand load, 16 quotient bits of a term and a test step each, one
// output load; only drain, setup and output load if a norm is zero. The next
// vector is taken the cycle after the result enters the output register.
// Stall: the result waits in the output register while result.ready is low;
// the next vector is accumulated meanwhile, and its result waits for the
// register to free.
// Reset: rst_n clears the accumulators, the controller and the output valid.
module cosine_similarity_unit import cosu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    cosu_in_if.sink    samples,
    cosu_out_if.source result
);

    cmd_t cmd;
    sts_t sts;

    cosu_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (samples.valid),
        .last_element (samples.last_element),
        .in_ready     (samples.ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    cosu_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .elem_a     (samples.elem_a),
        .elem_b     (samples.elem_b),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .similarity (result.similarity),
        .zero_norm  (result.zero_norm)
    );

endmodule
